@@ rtl/core/iqimp_pkg.sv @@
// ----------------------------------------------------------------------------
// I/Q impedance package
// Shared widths, constants, register indexes and the arctangent table of the
// vectoring CORDIC used by the impedance magnitude and phase unit.
// ----------------------------------------------------------------------------
package iqimp_pkg;

    // Sample and result widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 32;
    localparam int PHASE_W  = 16;

    // CORDIC datapath widths: samples enter shifted left, growth stays below 2^31
    localparam int PRE_SHIFT = 14;
    localparam int XY_W      = 33;
    localparam int Z_W       = 33;
    localparam int ATAN_W    = 32;

    // Stage count and table size
    localparam int ATAN_ENTRIES      = 24;
    localparam int DEF_CORDIC_STAGES = 16;

    // Angle units are 1/65536 centidegree
    localparam logic [31:0] INV_CORDIC_GAIN = 32'd2608131496;
    localparam logic [31:0] QUARTER_TURN    = 32'd589824000;
    localparam int          HALF_TURN_CDEG  = 18000;

    // Register reset values
    localparam logic [MAG_W-1:0] MAG_SCALE_RESET = 32'd65536;

    // Configuration register indexes
    typedef enum logic {
        REG_MAGNITUDE_SCALE = 1'b0,
        REG_GAIN_VALID      = 1'b1
    } t_cfg_index;

    // atan(2^-i), rounded to nearest, in 1/65536 centidegree
    function automatic logic [ATAN_W-1:0] atan_unit(input int idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            0:       v = 32'd294912000;
            1:       v = 32'd174096719;
            2:       v = 32'd91987925;
            3:       v = 32'd46694507;
            4:       v = 32'd23437865;
            5:       v = 32'd11730358;
            6:       v = 32'd5866610;
            7:       v = 32'd2933484;
            8:       v = 32'd1466764;
            9:       v = 32'd733385;
            10:      v = 32'd366693;
            11:      v = 32'd183346;
            12:      v = 32'd91673;
            13:      v = 32'd45837;
            14:      v = 32'd22918;
            15:      v = 32'd11459;
            16:      v = 32'd5730;
            17:      v = 32'd2865;
            18:      v = 32'd1432;
            19:      v = 32'd716;
            20:      v = 32'd358;
            21:      v = 32'd179;
            22:      v = 32'd90;
            23:      v = 32'd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/iq_impedance_magnitude_phase_unit.sv @@
// Pipeline: a word accepted on start passes the entry register, one register
// per CORDIC stage, two multiplier registers and the output register, then
// appears on the outputs with o_valid high. Throughput: one word per cycle
// while busy is low; every stage is registered and the receiver cannot stall.
// Reset: synchronous, active low; clears all valid bits, sets magnitude_scale to 1.0,
// marks the gain setting valid and holds busy high while reset is applied.
// ----------------------------------------------------------------------------
// I/Q impedance magnitude and phase unit
// Pipelined vectoring CORDIC on (-I, Q): gives the scaled, saturating vector
// length in Q16.16 and atan2(Q, -I) in hundredths of a degree.
// ----------------------------------------------------------------------------
module iq_impedance_magnitude_phase_unit #(
    parameter int CORDIC_STAGES = iqimp_pkg::DEF_CORDIC_STAGES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Sample command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [iqimp_pkg::SAMPLE_W-1:0]  i_in_phase_sample,
    input  logic signed [iqimp_pkg::SAMPLE_W-1:0]  i_quadrature_sample,
    // Configuration write port
    input  logic                                   i_cfg_we,
    input  iqimp_pkg::t_cfg_index                  i_cfg_index,
    input  logic [iqimp_pkg::MAG_W-1:0]            i_cfg_wdata,
    // Result channel
    output logic                                   o_valid,
    output logic [iqimp_pkg::MAG_W-1:0]            o_impedance_magnitude,
    output logic signed [iqimp_pkg::PHASE_W-1:0]   o_phase_centidegrees,
    output logic                                   o_gain_error
);
    import iqimp_pkg::*;

    localparam int PH_W = Z_W + 1 - 16;

    // Configuration registers
    logic [MAG_W-1:0] r_mag_scale;
    logic             r_gain_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_scale  <= MAG_SCALE_RESET;
            r_gain_valid <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAGNITUDE_SCALE: r_mag_scale  <= i_cfg_wdata;
                REG_GAIN_VALID:      r_gain_valid <= i_cfg_wdata[0];
                default:             r_mag_scale  <= r_mag_scale;
            endcase
        end
    end

    // Busy only in and just after reset: the pipeline takes a word every cycle
    logic r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy | ~i_rst_n;

    logic accept;
    assign accept = start & ~busy;

    // CORDIC stage registers; index 0 holds the pre-rotated vector
    logic                r_v [0:CORDIC_STAGES];
    logic                r_e [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] r_x [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] r_y [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  r_z [0:CORDIC_STAGES];

    // Pre-rotation into the right half plane
    logic signed [XY_W-1:0] pre_i, pre_q, pre_x;
    logic signed [XY_W-1:0] n_x0, n_y0;
    logic signed [Z_W-1:0]  n_z0;

    always_comb begin
        pre_i = {{(XY_W-SAMPLE_W){i_in_phase_sample[SAMPLE_W-1]}}, i_in_phase_sample}
                <<< PRE_SHIFT;
        pre_q = {{(XY_W-SAMPLE_W){i_quadrature_sample[SAMPLE_W-1]}}, i_quadrature_sample}
                <<< PRE_SHIFT;
        pre_x = -pre_i;
        if (pre_x < 0) begin
            if (pre_q >= 0) begin
                n_x0 = pre_q;
                n_y0 = pre_i;
                n_z0 = signed'({{(Z_W-32){1'b0}}, QUARTER_TURN});
            end else begin
                n_x0 = -pre_q;
                n_y0 = pre_x;
                n_z0 = -signed'({{(Z_W-32){1'b0}}, QUARTER_TURN});
            end
        end else begin
            n_x0 = pre_x;
            n_y0 = pre_q;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e[0] <= ~r_gain_valid;
        r_x[0] <= n_x0;
        r_y[0] <= n_y0;
        r_z[0] <= n_z0;
    end

    // Micro-rotation stages, one register each
    for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_stage
        localparam logic signed [Z_W-1:0] ATAN_K =
            signed'({{(Z_W-ATAN_W){1'b0}}, atan_unit(k-1)});
        logic signed [XY_W-1:0] sh_x, sh_y;
        assign sh_x = r_x[k-1] >>> (k-1);
        assign sh_y = r_y[k-1] >>> (k-1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_e[k] <= r_e[k-1];
            if (r_y[k-1] >= 0) begin
                r_x[k] <= r_x[k-1] + sh_y;
                r_y[k] <= r_y[k-1] - sh_x;
                r_z[k] <= r_z[k-1] + ATAN_K;
            end else begin
                r_x[k] <= r_x[k-1] - sh_y;
                r_y[k] <= r_y[k-1] + sh_x;
                r_z[k] <= r_z[k-1] - ATAN_K;
            end
        end
    end

    // Gain compensation: clamp negative length, multiply by 1/K
    logic [31:0]        x_pos;
    logic [63:0]        gain_prod;
    logic               r_mv, r_me;
    logic [31:0]        r_m;
    logic signed [Z_W-1:0] r_mz;

    assign x_pos     = (r_x[CORDIC_STAGES] < 0) ? '0 : r_x[CORDIC_STAGES][31:0];
    assign gain_prod = 64'(x_pos) * 64'(INV_CORDIC_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= r_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_me <= r_e[CORDIC_STAGES];
        r_m  <= gain_prod[63:32];
        r_mz <= r_z[CORDIC_STAGES];
    end

    // Apply the configured magnitude scale
    logic               r_pv, r_pe;
    logic [63:0]        r_p;
    logic signed [Z_W-1:0] r_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pe <= r_me;
        r_p  <= 64'(r_m) * 64'(r_mag_scale);
        r_pz <= r_mz;
    end

    // Round, saturate and convert the angle to centidegrees
    logic [64:0]            p_rnd;
    logic [64-PRE_SHIFT:0]  p_shift;
    logic [MAG_W-1:0]       mag_sat;
    logic signed [Z_W:0]    z_rnd;
    logic signed [PH_W-1:0] ph_full;
    logic signed [PHASE_W-1:0] ph_clamp;

    always_comb begin
        p_rnd   = {1'b0, r_p} + 65'(1 << (PRE_SHIFT - 1));
        p_shift = p_rnd[64:PRE_SHIFT];
        mag_sat = (|p_shift[64-PRE_SHIFT:MAG_W]) ? '1 : p_shift[MAG_W-1:0];

        z_rnd   = {r_pz[Z_W-1], r_pz} + (Z_W+1)'(32768);
        ph_full = PH_W'(z_rnd >>> 16);
        if (ph_full > PH_W'(HALF_TURN_CDEG)) begin
            ph_clamp = PHASE_W'(HALF_TURN_CDEG);
        end else if (ph_full < -PH_W'(HALF_TURN_CDEG)) begin
            ph_clamp = -PHASE_W'(HALF_TURN_CDEG);
        end else begin
            ph_clamp = ph_full[PHASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_pv;
        end
    end

    // Drop the result to zeros when the gain setting is invalid
    always_ff @(posedge i_clk) begin
        o_gain_error          <= r_pe;
        o_impedance_magnitude <= r_pe ? '0 : mag_sat;
        o_phase_centidegrees  <= r_pe ? '0 : ph_clamp;
    end

`ifndef SYNTHESIS
    // A word entering the pipeline is not lost: it leaves with o_valid high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> ##(CORDIC_STAGES + 3) o_valid)
        else $error("word lost in CORDIC pipeline");

    // An invalid gain setting gives zeroed fields
    a_gain_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gain_error) |->
            (o_impedance_magnitude == '0 && o_phase_centidegrees == '0))
        else $error("gain error with non-zero result");

    // Phase stays within a half turn
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_phase_centidegrees <= 16'sd18000 &&
                     o_phase_centidegrees >= -16'sd18000))
        else $error("phase outside half turn");
`endif

endmodule
